### rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the BMP pixel to tricolor converter.
// ----------------------------------------------------------------------------
package bpt_pkg;

   localparam int BPT_PALETTE_ENTRIES = 256;
   localparam int BPT_MAX_ROW_WIDTH   = 4096;
   localparam int BPT_COLUMN_SPAN     = 4096;
   localparam logic [12:0] BPT_WIDTH_LIMIT =
      13'((BPT_MAX_ROW_WIDTH < BPT_COLUMN_SPAN) ? BPT_MAX_ROW_WIDTH : BPT_COLUMN_SPAN);

   localparam int BPT_JOB_QUEUE_DEPTH = 2;
   localparam int BPT_MAX_PIXELS      = 8;

   // depth codes
   localparam logic [2:0] DEPTH_1BPP  = 3'd0;
   localparam logic [2:0] DEPTH_4BPP  = 3'd1;
   localparam logic [2:0] DEPTH_8BPP  = 3'd2;
   localparam logic [2:0] DEPTH_16BPP = 3'd3;
   localparam logic [2:0] DEPTH_24BPP = 3'd4;

   // pixel colors
   localparam logic [1:0] COLOR_BLACK = 2'd0;
   localparam logic [1:0] COLOR_WHITE = 2'd1;
   localparam logic [1:0] COLOR_RED   = 2'd2;

   // input actions
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_DATA = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_DEPTH_CODE    = 2'd0;
   localparam logic [1:0] CSR_RGB565_SELECT = 2'd1;
   localparam logic [1:0] CSR_COLOR_ENABLE  = 2'd2;
   localparam logic [1:0] CSR_ROW_WIDTH     = 2'd3;

   typedef struct packed {
      logic       action;
      logic       row_start;
      logic [7:0] data_byte;
      logic [7:0] palette_index;
      logic [7:0] pal_red;
      logic [7:0] pal_green;
      logic [7:0] pal_blue;
   } req_type;

   typedef struct packed {
      logic [1:0]  pixel_color;
      logic [11:0] pixel_column;
      logic        last_of_item;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  depth_code;
      logic        rgb565_select;
      logic        color_enable;
      logic [12:0] row_width;
   } cfg_type;

   typedef struct packed {
      logic [BPT_MAX_PIXELS-1:0][1:0] colors;
      logic [3:0]                     count;
      logic [11:0]                    column;
   } job_type;

endpackage

### rtl/bpt_front.sv
// ----------------------------------------------------------------------------
// bpt_front
// Accepts bytes and palette loads, gathers multi-byte pixels, looks up the
// palette, classifies colors and tracks the row column.
// ----------------------------------------------------------------------------
module bpt_front #(
   parameter int PALETTE_ENTRIES = bpt_pkg::BPT_PALETTE_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  bpt_pkg::cfg_type cfg,
   input  logic             push,
   output logic             full,
   input  bpt_pkg::req_type req_item,
   output logic             job_valid,
   output bpt_pkg::job_type job,
   input  logic             job_full
);
   import bpt_pkg::*;

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

   // {whitish, colored}
   logic [1:0] palette_mem [PALETTE_ENTRIES];

   logic        accept;
   logic        is_data;
   logic        color_mode;

   logic        load_white;
   logic        load_red;

   logic [7:0]  ra_full;
   logic [7:0]  rb_full;
   logic [1:0]  pa_ff;
   logic [1:0]  pb_ff;
   logic        pa_ok_ff;
   logic        pb_ok_ff;

   logic [1:0]  gc_ff;
   logic [1:0]  gc_in;
   logic [15:0] bg_ff;
   logic [15:0] bg_in;
   logic [1:0]  gc_eff;
   logic [15:0] bg_eff;
   logic        completes;

   logic [12:0] col_ff;
   logic [12:0] col_in;
   logic [12:0] col_eff;
   logic [12:0] width_lim;
   logic [12:0] avail;
   logic [3:0]  n_pix;
   logic [3:0]  m_pix;

   logic        s1_valid_ff;
   logic [7:0]  s1_db_ff;
   logic [7:0]  s1_lo_ff;
   logic [7:0]  s1_hi_ff;
   logic [3:0]  s1_count_ff;
   logic [11:0] s1_col_ff;

   logic [1:0]  color_a;
   logic [1:0]  color_b;
   logic [7:0]  ch_r;
   logic [7:0]  ch_g;
   logic [7:0]  ch_b;
   logic [1:0]  color_rgb;
   logic [BPT_MAX_PIXELS-1:0][1:0] colors;

   function automatic logic whitish(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic mode);
      logic [9:0] sum;
      sum = 10'(r) + 10'(g) + 10'(b);
      if (mode) begin
         return (r > 8'h80) && (g > 8'h80) && (b > 8'h80);
      end
      return sum > 10'd384;
   endfunction

   function automatic logic colored(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
      return (r > 8'hF0) || ((g > 8'hF0) && (b > 8'hF0));
   endfunction

   function automatic logic [1:0] pick(input logic w, input logic c, input logic mode);
      if (w) begin
         return COLOR_WHITE;
      end
      if (c && mode) begin
         return COLOR_RED;
      end
      return COLOR_BLACK;
   endfunction

   assign full       = s1_valid_ff && job_full;
   assign accept     = push && !full;
   assign is_data    = (req_item.action == ACTION_DATA);
   assign color_mode = cfg.color_enable && (cfg.depth_code != DEPTH_1BPP);

   // palette load
   assign load_white = whitish(req_item.pal_red, req_item.pal_green,
                               req_item.pal_blue, color_mode);
   assign load_red   = colored(req_item.pal_red, req_item.pal_green, req_item.pal_blue);

   always_ff @(posedge clock) begin
      if (accept && !is_data && ({1'b0, req_item.palette_index} < PAL_LIMIT)) begin
         palette_mem[req_item.palette_index[PAL_AW-1:0]] <= {load_white, load_red};
      end
   end

   // lookup addresses
   always_comb begin
      ra_full = 8'd0;
      rb_full = 8'd1;
      case (cfg.depth_code)
         DEPTH_4BPP: begin
            ra_full = {4'd0, req_item.data_byte[7:4]};
            rb_full = {4'd0, req_item.data_byte[3:0]};
         end
         DEPTH_8BPP: begin
            ra_full = req_item.data_byte;
            rb_full = 8'd0;
         end
         default: begin
            ra_full = 8'd0;
            rb_full = 8'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pa_ff    <= palette_mem[ra_full[PAL_AW-1:0]];
         pb_ff    <= palette_mem[rb_full[PAL_AW-1:0]];
         pa_ok_ff <= ({1'b0, ra_full} < PAL_LIMIT);
         pb_ok_ff <= ({1'b0, rb_full} < PAL_LIMIT);
      end
   end

   // byte gathering
   assign gc_eff = req_item.row_start ? 2'd0 : gc_ff;
   assign bg_eff = req_item.row_start ? 16'd0 : bg_ff;

   always_comb begin
      gc_in     = gc_eff;
      bg_in     = bg_eff;
      completes = 1'b0;
      case (cfg.depth_code)
         DEPTH_16BPP: begin
            if (gc_eff == 2'd0) begin
               bg_in = {8'd0, req_item.data_byte};
               gc_in = 2'd1;
            end else begin
               bg_in     = 16'd0;
               gc_in     = 2'd0;
               completes = 1'b1;
            end
         end
         DEPTH_24BPP: begin
            if (gc_eff == 2'd0) begin
               bg_in = {8'd0, req_item.data_byte};
               gc_in = 2'd1;
            end else if (gc_eff == 2'd1) begin
               bg_in = {req_item.data_byte, bg_eff[7:0]};
               gc_in = 2'd2;
            end else begin
               bg_in     = 16'd0;
               gc_in     = 2'd0;
               completes = 1'b1;
            end
         end
         default: begin
            gc_in     = gc_eff;
            bg_in     = bg_eff;
            completes = 1'b0;
         end
      endcase
   end

   // column tracking
   always_comb begin
      case (cfg.depth_code)
         DEPTH_1BPP:  n_pix = 4'd8;
         DEPTH_4BPP:  n_pix = 4'd2;
         DEPTH_8BPP:  n_pix = 4'd1;
         DEPTH_16BPP: n_pix = {3'd0, completes};
         DEPTH_24BPP: n_pix = {3'd0, completes};
         default:     n_pix = 4'd0;
      endcase
   end

   assign col_eff   = req_item.row_start ? 13'd0 : col_ff;
   assign width_lim = (cfg.row_width < BPT_WIDTH_LIMIT) ? cfg.row_width : BPT_WIDTH_LIMIT;
   assign avail     = (col_eff < width_lim) ? (width_lim - col_eff) : 13'd0;
   assign m_pix     = (avail < 13'(n_pix)) ? avail[3:0] : n_pix;
   assign col_in    = col_eff + 13'(m_pix);

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff       <= 2'd0;
         bg_ff       <= 16'd0;
         col_ff      <= 13'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && is_data) begin
            gc_ff  <= gc_in;
            bg_ff  <= bg_in;
            col_ff <= col_in;
         end
         if (accept) begin
            s1_valid_ff <= is_data && (m_pix != 4'd0);
         end else if (!job_full) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_db_ff    <= req_item.data_byte;
         s1_lo_ff    <= bg_eff[7:0];
         s1_hi_ff    <= bg_eff[15:8];
         s1_count_ff <= m_pix;
         s1_col_ff   <= col_eff[11:0];
      end
   end

   // color selection
   assign color_a = pick(pa_ok_ff && pa_ff[1], pa_ok_ff && pa_ff[0], color_mode);
   assign color_b = pick(pb_ok_ff && pb_ff[1], pb_ok_ff && pb_ff[0], color_mode);

   always_comb begin
      if (cfg.depth_code == DEPTH_16BPP) begin
         ch_b = {s1_lo_ff[4:0], 3'd0};
         if (cfg.rgb565_select) begin
            ch_g = {s1_db_ff[2:0], s1_lo_ff[7:5], 2'd0};
            ch_r = {s1_db_ff[7:3], 3'd0};
         end else begin
            ch_g = {s1_db_ff[1:0], s1_lo_ff[7:5], 3'd0};
            ch_r = {s1_db_ff[6:2], 3'd0};
         end
      end else begin
         ch_b = s1_lo_ff;
         ch_g = s1_hi_ff;
         ch_r = s1_db_ff;
      end
   end

   assign color_rgb = pick(whitish(ch_r, ch_g, ch_b, color_mode),
                           colored(ch_r, ch_g, ch_b), color_mode);

   always_comb begin
      colors = '0;
      case (cfg.depth_code)
         DEPTH_1BPP: begin
            for (int k = 0; k < BPT_MAX_PIXELS; k++) begin
               colors[k] = s1_db_ff[3'(7 - k)] ? color_b : color_a;
            end
         end
         DEPTH_4BPP: begin
            colors[0] = color_a;
            colors[1] = color_b;
         end
         DEPTH_8BPP: colors[0] = color_a;
         default:    colors[0] = color_rgb;
      endcase
   end

   assign job_valid  = s1_valid_ff;
   assign job.colors = colors;
   assign job.count  = s1_count_ff;
   assign job.column = s1_col_ff;

endmodule

### rtl/bpt_queue.sv
// ----------------------------------------------------------------------------
// bpt_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module bpt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  bpt_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output bpt_pkg::job_type head
);
   import bpt_pkg::*;

   localparam int AW = $clog2(BPT_JOB_QUEUE_DEPTH);
   localparam int CW = $clog2(BPT_JOB_QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(BPT_JOB_QUEUE_DEPTH - 1);

   job_type         slot_ff [BPT_JOB_QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CW'(BPT_JOB_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/bpt_back.sv
// ----------------------------------------------------------------------------
// bpt_back
// Serializes each job into pixels, one per cycle while the result register is popped or empty.
// ----------------------------------------------------------------------------
module bpt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  bpt_pkg::job_type q_head,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output bpt_pkg::rsp_type rsp_item
);
   import bpt_pkg::*;

   logic       cur_valid_ff;
   job_type    cur_ff;
   logic [2:0] idx_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   logic       advance;
   logic       take;
   logic       last;

   assign advance  = !out_valid_ff || pop;
   assign take     = cur_valid_ff && advance;
   assign last     = ((4'(idx_ff) + 4'd1) == cur_ff.count);
   assign q_pop    = !q_empty && (!cur_valid_ff || (take && last));
   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 3'd0;
         end else if (take && last) begin
            cur_valid_ff <= 1'b0;
         end else if (take) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (advance) begin
            out_valid_ff <= take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (take) begin
         out_ff.pixel_color  <= cur_ff.colors[idx_ff];
         out_ff.pixel_column <= cur_ff.column + 12'(idx_ff);
         out_ff.last_of_item <= last;
      end
   end

endmodule

### rtl/bmp_pixel_to_tricolor.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_tricolor
// BMP row bytes to black/white/red e-paper pixels, with palette loading.
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   input     push / full               req_item (req_type)
//   result    empty / pop               rsp_item (rsp_type)
//   config    csr_valid / csr_ready     csr_index, csr_data
//
// One input byte or palette load is taken per cycle while the result side
// keeps up; a byte yields 0 to 8 pixels, and the back part emits one pixel
// per cycle while the result side is popped or empty. Synchronous reset
// clears control, gather and column state; palette contents are not cleared.
// ----------------------------------------------------------------------------
module bmp_pixel_to_tricolor #(
   parameter int PALETTE_ENTRIES = bpt_pkg::BPT_PALETTE_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  bpt_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output bpt_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [12:0]      csr_data
);
   import bpt_pkg::*;

   cfg_type cfg_ff;
   logic    job_valid;
   job_type job;
   logic    job_full;
   logic    q_pop;
   logic    q_empty;
   job_type q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_code    <= DEPTH_24BPP;
         cfg_ff.rgb565_select <= 1'b1;
         cfg_ff.color_enable  <= 1'b0;
         cfg_ff.row_width     <= 13'd400;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEPTH_CODE:    cfg_ff.depth_code    <= csr_data[2:0];
            CSR_RGB565_SELECT: cfg_ff.rgb565_select <= csr_data[0];
            CSR_COLOR_ENABLE:  cfg_ff.color_enable  <= csr_data[0];
            CSR_ROW_WIDTH:     cfg_ff.row_width     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bpt_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .job_valid (job_valid),
      .job       (job),
      .job_full  (job_full)
   );

   bpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_job   (job),
      .full       (job_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   bpt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

### sim/bmp_pixel_to_tricolor_tb.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_tricolor_tb
// Self-checking bench for the BMP pixel to tricolor converter. A queue-fed
// driver offers palette loads and row bytes, and a scoreboard predicts every
// pixel beat from its own palette, gather and column state. A monitor pops
// beats with random stalls and compares them field by field, in order.
// ----------------------------------------------------------------------------
module bmp_pixel_to_tricolor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpt_pkg::*;

   localparam int PHASE_ITEMS   = 27;
   localparam int PHASE_COUNT   = 12;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 12;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        push      = 1'b0;
   logic        full;
   req_type     req_item  = '0;
   logic        empty;
   logic        pop       = 1'b0;
   rsp_type     rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_DEPTH_CODE;
   logic [12:0] csr_data  = '0;

   bmp_pixel_to_tricolor dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // scoreboard state
   cfg_type     cfg_now = '{DEPTH_24BPP, 1'b1, 1'b0, 13'd400};
   bit          pal_white [256];
   bit          pal_red   [256];
   logic [15:0] gather_bytes = '0;
   logic [1:0]  gather_cnt   = '0;
   logic [12:0] col_count    = '0;
   rsp_type     pixel_expect_q [$];

   // stimulus state
   req_type     byte_pend_q [$];
   bit          pal_known [256];
   logic [7:0]  pal_known_q [$];
   int          fail_count    = 0;
   int          hold_requests = 0;
   int          hold_taken    = 0;
   int          hold_left     = 0;
   int          send_gap      = 0;
   int          send_calm     = 0;
   int          pop_gap       = 0;
   int          pop_calm      = 0;

   function automatic bit color_mode();
      return cfg_now.color_enable && cfg_now.depth_code != DEPTH_1BPP;
   endfunction

   function automatic bit whitish(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (color_mode())
         return r > 8'h80 && g > 8'h80 && b > 8'h80;
      return (10'(r) + 10'(g) + 10'(b)) > 10'd384;
   endfunction

   function automatic bit colored(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return r > 8'hF0 || (g > 8'hF0 && b > 8'hF0);
   endfunction

   function automatic logic [1:0] tricolor(bit w, bit c);
      if (w)
         return COLOR_WHITE;
      if (c && color_mode())
         return COLOR_RED;
      return COLOR_BLACK;
   endfunction

   function automatic void emit_pixel(logic [1:0] color);
      logic [12:0] lim;
      rsp_type     px;
      lim = (cfg_now.row_width < BPT_WIDTH_LIMIT) ? cfg_now.row_width : BPT_WIDTH_LIMIT;
      if (col_count >= lim)
         return;
      px.pixel_color  = color;
      px.pixel_column = col_count[11:0];
      px.last_of_item = 1'b0;
      pixel_expect_q.push_back(px);
      col_count = col_count + 13'd1;
   endfunction

   function automatic void emit_index(logic [7:0] idx);
      emit_pixel(tricolor(pal_white[idx], pal_red[idx]));
   endfunction

   function automatic void emit_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      emit_pixel(tricolor(whitish(r, g, b), colored(r, g, b)));
   endfunction

   function automatic void predict_pixels(req_type it);
      int         first;
      logic [7:0] lsb;
      logic [7:0] msb;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      rsp_type    px;
      first = pixel_expect_q.size();
      if (it.action == ACTION_LOAD) begin
         pal_white[it.palette_index] = whitish(it.pal_red, it.pal_green, it.pal_blue);
         pal_red[it.palette_index]   = colored(it.pal_red, it.pal_green, it.pal_blue);
         return;
      end
      if (it.row_start) begin
         gather_bytes = '0;
         gather_cnt   = '0;
         col_count    = '0;
      end
      msb = it.data_byte;
      case (cfg_now.depth_code)
         DEPTH_1BPP: begin
            for (int k = 7; k >= 0; k--)
               emit_index({7'd0, msb[k]});
         end
         DEPTH_4BPP: begin
            emit_index({4'd0, msb[7:4]});
            emit_index({4'd0, msb[3:0]});
         end
         DEPTH_8BPP: begin
            emit_index(msb);
         end
         DEPTH_16BPP: begin
            if (gather_cnt == 2'd0) begin
               gather_bytes = {8'd0, msb};
               gather_cnt   = 2'd1;
            end else begin
               lsb = gather_bytes[7:0];
               b   = {lsb[4:0], 3'b000};
               if (!cfg_now.rgb565_select) begin
                  g = {msb[1:0], lsb[7:5], 3'b000};
                  r = {msb[6:2], 3'b000};
               end else begin
                  g = {msb[2:0], lsb[7:5], 2'b00};
                  r = {msb[7:3], 3'b000};
               end
               gather_bytes = '0;
               gather_cnt   = '0;
               emit_rgb(r, g, b);
            end
         end
         DEPTH_24BPP: begin
            if (gather_cnt == 2'd0) begin
               gather_bytes = {8'd0, msb};
               gather_cnt   = 2'd1;
            end else if (gather_cnt == 2'd1) begin
               gather_bytes[15:8] = msb;
               gather_cnt         = 2'd2;
            end else begin
               g = gather_bytes[15:8];
               b = gather_bytes[7:0];
               gather_bytes = '0;
               gather_cnt   = '0;
               emit_rgb(msb, g, b);
            end
         end
         default: ;
      endcase
      if (pixel_expect_q.size() > first) begin
         px = pixel_expect_q.pop_back();
         px.last_of_item = 1'b1;
         pixel_expect_q.push_back(px);
      end
   endfunction

   task automatic report_mismatch(string msg);
      fail_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic check_pixel(rsp_type got);
      rsp_type want;
      if (pixel_expect_q.size() == 0) begin
         report_mismatch($sformatf("beat with nothing expected, column %0d",
                                   got.pixel_column));
         return;
      end
      want = pixel_expect_q.pop_front();
      if (got.pixel_color !== want.pixel_color)
         report_mismatch($sformatf("pixel_color col %0d: want %0d got %0d",
                                   want.pixel_column, want.pixel_color, got.pixel_color));
      if (got.pixel_column !== want.pixel_column)
         report_mismatch($sformatf("pixel_column: want %0d got %0d",
                                   want.pixel_column, got.pixel_column));
      if (got.last_of_item !== want.last_of_item)
         report_mismatch($sformatf("last_of_item col %0d: want %0d got %0d",
                                   want.pixel_column, want.last_of_item, got.last_of_item));
   endtask

   // mostly short idles, a few long ones
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push     <= 1'b0;
         req_item <= '0;
         send_gap  = 0;
      end else begin
         if (push && !full)
            predict_pixels(req_item);
         if (!(push && full)) begin
            if (send_gap > 0) begin
               send_gap--;
               push <= 1'b0;
            end else if (byte_pend_q.size() != 0) begin
               req_item <= byte_pend_q.pop_front();
               push     <= 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
                  send_gap = 0;
               end else begin
                  send_gap = idle_len();
                  if ($urandom_range(0, 24) == 0)
                     send_calm = $urandom_range(15, 50);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            check_pixel(rsp_item);
         if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = LONG_HOLD;
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (pop && !empty) begin
               if (pop_calm > 0) begin
                  pop_calm--;
                  pop_gap = 0;
               end else begin
                  pop_gap = idle_len();
                  if ($urandom_range(0, 24) == 0)
                     pop_calm = $urandom_range(15, 50);
               end
            end
            if (pop_gap > 0) begin
               pop_gap--;
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 11))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h81;
         4: return 8'hF0;
         5: return 8'hF1;
         6: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_data_byte();
      if (cfg_now.depth_code == DEPTH_8BPP)
         return pal_known_q[$urandom_range(0, pal_known_q.size() - 1)];
      return rand_chan();
   endfunction

   function automatic void queue_data(bit rs, logic [7:0] db);
      req_type it;
      it.action        = ACTION_DATA;
      it.row_start     = rs;
      it.data_byte     = db;
      it.palette_index = 8'($urandom);
      it.pal_red       = 8'($urandom);
      it.pal_green     = 8'($urandom);
      it.pal_blue      = 8'($urandom);
      byte_pend_q.push_back(it);
   endfunction

   function automatic void queue_load(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
      req_type it;
      it.action        = ACTION_LOAD;
      it.row_start     = 1'($urandom);
      it.data_byte     = 8'($urandom);
      it.palette_index = idx;
      it.pal_red       = r;
      it.pal_green     = g;
      it.pal_blue      = b;
      byte_pend_q.push_back(it);
      if (!pal_known[idx]) begin
         pal_known[idx] = 1'b1;
         pal_known_q.push_back(idx);
      end
   endfunction

   // BMP stores 24-bit pixels blue first
   function automatic void queue_pixel24(bit rs, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
      queue_data(rs, b);
      queue_data(1'b0, g);
      queue_data(1'b0, r);
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [12:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEPTH_CODE:    cfg_now.depth_code    = val[2:0];
         CSR_RGB565_SELECT: cfg_now.rgb565_select = val[0];
         CSR_COLOR_ENABLE:  cfg_now.color_enable  = val[0];
         CSR_ROW_WIDTH:     cfg_now.row_width     = val;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [2:0] depth, bit sel565, bit color, logic [12:0] width);
      csr_write(CSR_DEPTH_CODE, {10'd0, depth});
      csr_write(CSR_RGB565_SELECT, {12'd0, sel565});
      csr_write(CSR_COLOR_ENABLE, {12'd0, color});
      csr_write(CSR_ROW_WIDTH, width);
      @(negedge clock);
   endtask

   task automatic wait_drained(int extra);
      while (byte_pend_q.size() != 0 || push || pixel_expect_q.size() != 0)
         @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // mostly whole rows, some stray loads and continuation bytes
   task automatic gen_phase(int n);
      int made;
      int row_len;
      made = 0;
      while (made < n) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_load(8'($urandom), rand_chan(), rand_chan(), rand_chan());
               made++;
            end
            1: begin
               queue_data(1'b0, rand_data_byte());
               made++;
            end
            default: begin
               row_len = $urandom_range(1, 24);
               if (row_len > n - made)
                  row_len = n - made;
               for (int k = 0; k < row_len; k++)
                  queue_data(k == 0, rand_data_byte());
               made += row_len;
            end
         endcase
      end
   endtask

   task automatic phase_config(int p);
      logic [12:0] width;
      case (p)
         0: set_config(DEPTH_24BPP, 1'b0, 1'b0, 13'd11);
         1: set_config(DEPTH_16BPP, 1'b0, 1'b1, 13'd5);
         2: set_config(DEPTH_16BPP, 1'b1, 1'b0, 13'd7);
         3: set_config(DEPTH_1BPP, 1'b0, 1'b1, 13'd13);
         4: set_config(DEPTH_4BPP, 1'b1, 1'b1, 13'd9);
         5: set_config(DEPTH_8BPP, 1'b0, 1'b0, 13'd1);
         6: set_config(DEPTH_8BPP, 1'b1, 1'b1, BPT_WIDTH_LIMIT);
         7: set_config(DEPTH_1BPP, 1'b1, 1'b0, BPT_WIDTH_LIMIT);
         8: set_config(DEPTH_16BPP, 1'b1, 1'b1, 13'd2);
         default: begin
            width = ($urandom_range(0, 5) == 0) ? BPT_WIDTH_LIMIT
                                                : 13'($urandom_range(1, 40));
            set_config(3'($urandom_range(0, 4)), 1'($urandom), 1'($urandom), width);
         end
      endcase
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: 24 bpp, sum threshold, no red
      queue_pixel24(1'b1, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel24(1'b0, 8'h00, 8'h00, 8'h00);
      queue_pixel24(1'b0, 8'h80, 8'h80, 8'h80);
      queue_pixel24(1'b0, 8'h81, 8'h80, 8'h80);
      queue_pixel24(1'b0, 8'hFF, 8'h00, 8'h00);
      wait_drained(SETTLE_CYCLES);

      // color mode, narrow row: red by R, red by G+B, white, then clipped
      set_config(DEPTH_24BPP, 1'b1, 1'b1, 13'd3);
      queue_pixel24(1'b1, 8'hFF, 8'h00, 8'h00);
      queue_pixel24(1'b0, 8'h80, 8'hFF, 8'hFF);
      queue_pixel24(1'b0, 8'h81, 8'h81, 8'h81);
      queue_pixel24(1'b0, 8'hFF, 8'hFF, 8'h00);

      // palette entries used by 1, 4 and 8 bpp
      queue_load(8'd0, 8'h00, 8'h00, 8'h00);
      for (int k = 1; k < 16; k++)
         queue_load(8'(k), rand_chan(), rand_chan(), rand_chan());
      queue_load(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_drained(SETTLE_CYCLES);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         phase_config(p);
         if (p == 3 || p == 10)
            hold_requests++;
         gen_phase(PHASE_ITEMS / 2);
         if (p % 4 == 1)
            wait_drained(0);
         gen_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
         wait_drained(SETTLE_CYCLES);
      end

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
